// ===== rtl/core/dpd_pkg.sv =====
// ----------------------------------------------------------------------------
// dpd_pkg: shared types, constants and fixed-point helpers
// Holds the register map, the configuration bundle and the round/saturate
// helpers used by every stage of the depth pixel deprojection pipeline.
// ----------------------------------------------------------------------------
package dpd_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] CfgPrincipalX   = 3'd0;
    localparam logic [2:0] CfgPrincipalY   = 3'd1;
    localparam logic [2:0] CfgInvFocalX    = 3'd2;
    localparam logic [2:0] CfgInvFocalY    = 3'd3;
    localparam logic [2:0] CfgRadialK1     = 3'd4;
    localparam logic [2:0] CfgRadialK2     = 3'd5;
    localparam logic [2:0] CfgRadialK3     = 3'd6;
    localparam logic [2:0] CfgTangential   = 3'd7;

    // Depth scale 0.000124986647 m per unit in Q0.48, split as Hi * 2^18 + Lo.
    localparam logic [17:0] DepthScaleHi   = 18'd134203;
    localparam logic [17:0] DepthScaleLo   = 18'd102321;

    // One in Q7.24.
    localparam logic signed [63:0] OneQ24  = 64'sd16777216;

    localparam logic signed [63:0] SatMax  = 64'sd2147483647;
    localparam logic signed [63:0] SatMin  = -64'sd2147483648;

    // Register stages in the lens correction pipeline.
    localparam int DistLatency = 13;

    typedef struct packed {
        logic        [19:0] principal_x;
        logic        [19:0] principal_y;
        logic        [31:0] inv_focal_x;
        logic        [31:0] inv_focal_y;
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] k3;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
    } t_cfg;

    // Clamp to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SatMax) begin
            r = 32'sh7FFFFFFF;
        end else if (v < SatMin) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Round half up by sh bits, then clamp.
    function automatic logic signed [31:0] rnd_sat(input logic signed [63:0] v,
                                                   input int unsigned sh);
        logic signed [63:0] t;
        t = (v + (64'sd1 <<< (sh - 1))) >>> sh;
        return sat32(t);
    endfunction

endpackage

// ===== rtl/core/dpd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dpd_cfg_regs: configuration register file
// Eight registers written by index; presented to the pipeline as one bundle.
// ----------------------------------------------------------------------------
module dpd_cfg_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [2:0]           i_wr_index,
    input  logic [63:0]          i_wr_data,
    output dpd_pkg::t_cfg        o_cfg
);

    logic [19:0] r_principal_x;
    logic [19:0] r_principal_y;
    logic [31:0] r_inv_focal_x;
    logic [31:0] r_inv_focal_y;
    logic [31:0] r_radial_k1;
    logic [31:0] r_radial_k2;
    logic [31:0] r_radial_k3;
    logic [63:0] r_tangential;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_principal_x <= '0;
            r_principal_y <= '0;
            r_inv_focal_x <= '0;
            r_inv_focal_y <= '0;
            r_radial_k1   <= '0;
            r_radial_k2   <= '0;
            r_radial_k3   <= '0;
            r_tangential  <= '0;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                dpd_pkg::CfgPrincipalX: r_principal_x <= i_wr_data[19:0];
                dpd_pkg::CfgPrincipalY: r_principal_y <= i_wr_data[19:0];
                dpd_pkg::CfgInvFocalX:  r_inv_focal_x <= i_wr_data[31:0];
                dpd_pkg::CfgInvFocalY:  r_inv_focal_y <= i_wr_data[31:0];
                dpd_pkg::CfgRadialK1:   r_radial_k1   <= i_wr_data[31:0];
                dpd_pkg::CfgRadialK2:   r_radial_k2   <= i_wr_data[31:0];
                dpd_pkg::CfgRadialK3:   r_radial_k3   <= i_wr_data[31:0];
                dpd_pkg::CfgTangential: r_tangential  <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg.principal_x = r_principal_x;
    assign o_cfg.principal_y = r_principal_y;
    assign o_cfg.inv_focal_x = r_inv_focal_x;
    assign o_cfg.inv_focal_y = r_inv_focal_y;
    assign o_cfg.k1          = $signed(r_radial_k1);
    assign o_cfg.k2          = $signed(r_radial_k2);
    assign o_cfg.k3          = $signed(r_radial_k3);
    assign o_cfg.p1          = $signed(r_tangential[31:0]);
    assign o_cfg.p2          = $signed(r_tangential[63:32]);

endmodule

// ===== rtl/core/dpd_normalize.sv =====
// ----------------------------------------------------------------------------
// dpd_normalize: pixel normalization and depth scaling
// Three stages: center on the principal point, multiply by the reciprocal
// focal lengths and the depth scale, then round and saturate.
// ----------------------------------------------------------------------------
module dpd_normalize #(
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dpd_pkg::t_cfg               i_cfg,
    input  logic                        i_valid,
    input  logic [COORD_BITS-1:0]       i_column,
    input  logic [COORD_BITS-1:0]       i_row,
    input  logic [DEPTH_BITS-1:0]       i_raw,
    output logic                        o_valid,
    output logic signed [31:0]          o_x,
    output logic signed [31:0]          o_y,
    output logic [DEPTH_BITS+7:0]       o_z
);

    // Centered coordinate must hold both the shifted pixel and the 20-bit center.
    localparam int DW = ((COORD_BITS + 8 > 20) ? COORD_BITS + 8 : 20) + 1;
    localparam int PW = DW + 33;
    localparam int ZW = DEPTH_BITS + 8;
    localparam int SW = DEPTH_BITS + 37;

    localparam logic [DEPTH_BITS+17:0] DepthScaleHiW = (DEPTH_BITS + 18)'(dpd_pkg::DepthScaleHi);
    localparam logic [DEPTH_BITS+17:0] DepthScaleLoW = (DEPTH_BITS + 18)'(dpd_pkg::DepthScaleLo);

    logic [2:0]                r_vld;
    logic signed [DW-1:0]      r_dx;
    logic signed [DW-1:0]      r_dy;
    logic [DEPTH_BITS-1:0]     r_raw;
    logic signed [PW-1:0]      r_px_p;
    logic signed [PW-1:0]      r_py_p;
    logic [DEPTH_BITS+17:0]    r_zh_p;
    logic [DEPTH_BITS+17:0]    r_zl_p;
    logic signed [31:0]        r_x;
    logic signed [31:0]        r_y;
    logic [ZW-1:0]             r_z;
    logic [SW-1:0]             w_zsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    assign w_zsum = (SW'(r_zh_p) << 18) + SW'(r_zl_p) + (SW'(1) << 27);

    always_ff @(posedge i_clk) begin
        r_dx   <= $signed(DW'({i_column, 8'b0})) - $signed(DW'(i_cfg.principal_x));
        r_dy   <= $signed(DW'({i_row, 8'b0})) - $signed(DW'(i_cfg.principal_y));
        r_raw  <= i_raw;

        r_px_p <= r_dx * $signed({1'b0, i_cfg.inv_focal_x});
        r_py_p <= r_dy * $signed({1'b0, i_cfg.inv_focal_y});
        r_zh_p <= r_raw * DepthScaleHiW;
        r_zl_p <= r_raw * DepthScaleLoW;

        r_x    <= dpd_pkg::rnd_sat(64'(r_px_p), 16);
        r_y    <= dpd_pkg::rnd_sat(64'(r_py_p), 16);
        r_z    <= w_zsum[ZW+27:28];
    end

    assign o_valid = r_vld[2];
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

// ===== rtl/core/dpd_distort.sv =====
// ----------------------------------------------------------------------------
// dpd_distort: Brown-Conrady correction pipeline
// Thirteen stages that alternate multiply, round/saturate and saturating
// sums to form the corrected normalized coordinates in Q7.24.
// ----------------------------------------------------------------------------
module dpd_distort (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dpd_pkg::t_cfg        i_cfg,
    input  logic                 i_valid,
    input  logic signed [31:0]   i_x,
    input  logic signed [31:0]   i_y,
    output logic                 o_valid,
    output logic signed [31:0]   o_ux,
    output logic signed [31:0]   o_uy
);

    localparam int L = dpd_pkg::DistLatency;

    logic [L-1:0] r_vld;

    // Stage 1: squares and cross product.
    logic signed [63:0] r1_xx_p, r1_yy_p, r1_xy_p;
    logic signed [31:0] r1_x, r1_y;
    // Stage 2: rounded squares.
    logic signed [31:0] r2_xx, r2_yy, r2_xy, r2_x, r2_y;
    // Stage 3: r squared.
    logic signed [31:0] r3_r2, r3_xx, r3_yy, r3_xy, r3_x, r3_y;
    // Stage 4: r^4 and k1 term products, tangential sums.
    logic signed [63:0] r4_r4_p, r4_m1_p;
    logic signed [31:0] r4_sx, r4_sy, r4_r2, r4_xy, r4_x, r4_y;
    // Stage 5.
    logic signed [31:0] r5_r4, r5_m1, r5_r2, r5_xy, r5_sx, r5_sy, r5_x, r5_y;
    // Stage 6: r^6, k2 term and tangential products.
    logic signed [63:0] r6_r6_p, r6_m2_p, r6_t1x_p, r6_t1y_p, r6_t2x_p, r6_t2y_p;
    logic signed [31:0] r6_m1, r6_x, r6_y;
    // Stage 7.
    logic signed [31:0] r7_r6, r7_m2, r7_t1x, r7_t1y, r7_t2x, r7_t2y, r7_m1, r7_x, r7_y;
    // Stage 8: k3 term product.
    logic signed [63:0] r8_m3_p;
    logic signed [31:0] r8_m1, r8_m2, r8_t1x, r8_t1y, r8_t2x, r8_t2y, r8_x, r8_y;
    // Stage 9.
    logic signed [31:0] r9_m3, r9_m1, r9_m2, r9_t1x, r9_t1y, r9_t2x, r9_t2y, r9_x, r9_y;
    // Stage 10: radial factor.
    logic signed [31:0] r10_f, r10_t1x, r10_t1y, r10_t2x, r10_t2y, r10_x, r10_y;
    // Stage 11: coordinate times radial factor.
    logic signed [63:0] r11_ax_p, r11_ay_p;
    logic signed [31:0] r11_t1x, r11_t1y, r11_t2x, r11_t2y;
    // Stage 12.
    logic signed [31:0] r12_ax, r12_ay, r12_t1x, r12_t1y, r12_t2x, r12_t2y;
    // Stage 13: corrected coordinates.
    logic signed [31:0] r13_ux, r13_uy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[L-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_xx_p <= i_x * i_x;
        r1_yy_p <= i_y * i_y;
        r1_xy_p <= i_x * i_y;
        r1_x    <= i_x;
        r1_y    <= i_y;

        r2_xx <= dpd_pkg::rnd_sat(r1_xx_p, 24);
        r2_yy <= dpd_pkg::rnd_sat(r1_yy_p, 24);
        r2_xy <= dpd_pkg::rnd_sat(r1_xy_p, 24);
        r2_x  <= r1_x;
        r2_y  <= r1_y;

        r3_r2 <= dpd_pkg::sat32(64'(r2_xx) + 64'(r2_yy));
        r3_xx <= r2_xx;
        r3_yy <= r2_yy;
        r3_xy <= r2_xy;
        r3_x  <= r2_x;
        r3_y  <= r2_y;

        r4_r4_p <= r3_r2 * r3_r2;
        r4_m1_p <= i_cfg.k1 * r3_r2;
        r4_sx   <= dpd_pkg::sat32(64'(r3_r2) + (64'(r3_xx) <<< 1));
        r4_sy   <= dpd_pkg::sat32(64'(r3_r2) + (64'(r3_yy) <<< 1));
        r4_r2   <= r3_r2;
        r4_xy   <= r3_xy;
        r4_x    <= r3_x;
        r4_y    <= r3_y;

        r5_r4 <= dpd_pkg::rnd_sat(r4_r4_p, 24);
        r5_m1 <= dpd_pkg::rnd_sat(r4_m1_p, 24);
        r5_r2 <= r4_r2;
        r5_xy <= r4_xy;
        r5_sx <= r4_sx;
        r5_sy <= r4_sy;
        r5_x  <= r4_x;
        r5_y  <= r4_y;

        r6_r6_p  <= r5_r4 * r5_r2;
        r6_m2_p  <= i_cfg.k2 * r5_r4;
        r6_t1x_p <= i_cfg.p1 * r5_xy;
        r6_t1y_p <= i_cfg.p2 * r5_xy;
        r6_t2x_p <= i_cfg.p2 * r5_sx;
        r6_t2y_p <= i_cfg.p1 * r5_sy;
        r6_m1    <= r5_m1;
        r6_x     <= r5_x;
        r6_y     <= r5_y;

        r7_r6  <= dpd_pkg::rnd_sat(r6_r6_p, 24);
        r7_m2  <= dpd_pkg::rnd_sat(r6_m2_p, 24);
        r7_t1x <= dpd_pkg::rnd_sat(r6_t1x_p, 24);
        r7_t1y <= dpd_pkg::rnd_sat(r6_t1y_p, 24);
        r7_t2x <= dpd_pkg::rnd_sat(r6_t2x_p, 24);
        r7_t2y <= dpd_pkg::rnd_sat(r6_t2y_p, 24);
        r7_m1  <= r6_m1;
        r7_x   <= r6_x;
        r7_y   <= r6_y;

        r8_m3_p <= i_cfg.k3 * r7_r6;
        r8_m1   <= r7_m1;
        r8_m2   <= r7_m2;
        r8_t1x  <= r7_t1x;
        r8_t1y  <= r7_t1y;
        r8_t2x  <= r7_t2x;
        r8_t2y  <= r7_t2y;
        r8_x    <= r7_x;
        r8_y    <= r7_y;

        r9_m3  <= dpd_pkg::rnd_sat(r8_m3_p, 24);
        r9_m1  <= r8_m1;
        r9_m2  <= r8_m2;
        r9_t1x <= r8_t1x;
        r9_t1y <= r8_t1y;
        r9_t2x <= r8_t2x;
        r9_t2y <= r8_t2y;
        r9_x   <= r8_x;
        r9_y   <= r8_y;

        r10_f   <= dpd_pkg::sat32(dpd_pkg::OneQ24 + 64'(r9_m1) + 64'(r9_m2) + 64'(r9_m3));
        r10_t1x <= r9_t1x;
        r10_t1y <= r9_t1y;
        r10_t2x <= r9_t2x;
        r10_t2y <= r9_t2y;
        r10_x   <= r9_x;
        r10_y   <= r9_y;

        r11_ax_p <= r10_x * r10_f;
        r11_ay_p <= r10_y * r10_f;
        r11_t1x  <= r10_t1x;
        r11_t1y  <= r10_t1y;
        r11_t2x  <= r10_t2x;
        r11_t2y  <= r10_t2y;

        r12_ax  <= dpd_pkg::rnd_sat(r11_ax_p, 24);
        r12_ay  <= dpd_pkg::rnd_sat(r11_ay_p, 24);
        r12_t1x <= r11_t1x;
        r12_t1y <= r11_t1y;
        r12_t2x <= r11_t2x;
        r12_t2y <= r11_t2y;

        r13_ux <= dpd_pkg::sat32(64'(r12_ax) + (64'(r12_t1x) <<< 1) + 64'(r12_t2x));
        r13_uy <= dpd_pkg::sat32(64'(r12_ay) + (64'(r12_t1y) <<< 1) + 64'(r12_t2y));
    end

    assign o_valid = r_vld[L-1];
    assign o_ux    = r13_ux;
    assign o_uy    = r13_uy;

endmodule

// ===== rtl/core/dpd_project.sv =====
// ----------------------------------------------------------------------------
// dpd_project: depth projection
// Two stages: multiply the corrected coordinates by the metric depth, then
// round and saturate to Q11.20.
// ----------------------------------------------------------------------------
module dpd_project #(
    parameter int DEPTH_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic signed [31:0]          i_ux,
    input  logic signed [31:0]          i_uy,
    input  logic [DEPTH_BITS+7:0]       i_z,
    output logic                        o_valid,
    output logic signed [31:0]          o_px,
    output logic signed [31:0]          o_py,
    output logic signed [31:0]          o_pz
);

    localparam int ZW = DEPTH_BITS + 8;

    logic [1:0]               r_vld;
    logic signed [ZW+32:0]    r_px_p;
    logic signed [ZW+32:0]    r_py_p;
    logic [ZW-1:0]            r_z;
    logic signed [31:0]       r_px;
    logic signed [31:0]       r_py;
    logic signed [31:0]       r_pz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_px_p <= $signed({1'b0, i_z}) * i_ux;
        r_py_p <= $signed({1'b0, i_z}) * i_uy;
        r_z    <= i_z;

        r_px   <= dpd_pkg::rnd_sat(64'(r_px_p), 24);
        r_py   <= dpd_pkg::rnd_sat(64'(r_py_p), 24);
        r_pz   <= $signed(32'(r_z));
    end

    assign o_valid = r_vld[1];
    assign o_px    = r_px;
    assign o_py    = r_py;
    assign o_pz    = r_pz;

endmodule

// ===== rtl/core/depth_pixel_deproject.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_deproject: depth pixel to 3D point with lens correction
// Turns a depth pixel (column, row, raw depth) into a metric 3D point using
// the principal point, reciprocal focal lengths and a Brown-Conrady model.
// ----------------------------------------------------------------------------
//
// Channel     Direction  Handshake                      Payload
// ----------  ---------  -----------------------------  -------------------------------
// pixel       in         i_start high, o_busy low       i_pixel_column, i_pixel_row,
//                                                       i_raw_depth
// point       out        o_result_valid one-cycle pulse o_point_x, o_point_y, o_point_z
// config      in         i_cfg_valid and o_cfg_ready    i_cfg_index, i_cfg_data
//
// One pixel request can enter in every clock cycle while o_busy is low; its point passes
// through normalization and depth scaling, lens correction and projection in that order,
// and every product is registered before it is rounded and saturated. Reset is
// synchronous and active low; it clears the configuration registers and every valid bit,
// and o_busy is high only while reset is held. The receiver cannot stall, so nothing
// stops the pipeline. Configuration writes are always accepted and belong between bursts.
//
module depth_pixel_deproject #(
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Pixel requests.
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [COORD_BITS-1:0]       i_pixel_column,
    input  logic [COORD_BITS-1:0]       i_pixel_row,
    input  logic [DEPTH_BITS-1:0]       i_raw_depth,
    // Results.
    output logic                        o_result_valid,
    output logic signed [31:0]          o_point_x,
    output logic signed [31:0]          o_point_y,
    output logic signed [31:0]          o_point_z,
    // Configuration writes.
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [2:0]                  i_cfg_index,
    input  logic [63:0]                 i_cfg_data
);

    localparam int ZW = DEPTH_BITS + 8;
    localparam int L  = dpd_pkg::DistLatency;
    localparam int TotalLatency = 3 + L + 2;

    dpd_pkg::t_cfg        cfg;
    logic                 req_accept;

    logic                 norm_valid;
    logic signed [31:0]   norm_x;
    logic signed [31:0]   norm_y;
    logic [ZW-1:0]        norm_z;

    logic                 dist_valid;
    logic signed [31:0]   dist_ux;
    logic signed [31:0]   dist_uy;

    // Depth rides alongside the lens correction stages.
    logic [ZW-1:0]        r_z_dly [L];

    // The pipeline accepts a request in every cycle; only reset holds it off.
    assign o_busy      = ~i_rst_n;
    assign o_cfg_ready = 1'b1;
    assign req_accept  = i_start & ~o_busy;

    dpd_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid & o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Center and scale the pixel, and convert raw depth to metres.
    dpd_normalize #(
        .COORD_BITS (COORD_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_normalize (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (req_accept),
        .i_column (i_pixel_column),
        .i_row    (i_pixel_row),
        .i_raw    (i_raw_depth),
        .o_valid  (norm_valid),
        .o_x      (norm_x),
        .o_y      (norm_y),
        .o_z      (norm_z)
    );

    // Radial and tangential correction of the normalized coordinates.
    dpd_distort u_distort (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (norm_valid),
        .i_x     (norm_x),
        .i_y     (norm_y),
        .o_valid (dist_valid),
        .o_ux    (dist_ux),
        .o_uy    (dist_uy)
    );

    always_ff @(posedge i_clk) begin
        r_z_dly[0] <= norm_z;
        for (int i = 1; i < L; i++) begin
            r_z_dly[i] <= r_z_dly[i-1];
        end
    end

    // Scale the corrected direction by depth.
    dpd_project #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_project (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dist_valid),
        .i_ux    (dist_ux),
        .i_uy    (dist_uy),
        .i_z     (r_z_dly[L-1]),
        .o_valid (o_result_valid),
        .o_px    (o_point_x),
        .o_py    (o_point_y),
        .o_pz    (o_point_z)
    );

    // A result strobe always traces back to a request the full latency earlier.
    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(req_accept, TotalLatency))
        else $error("result strobe without a matching request");

    // Depth is scaled from an unsigned reading and can never come out negative.
    a_depth_not_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !o_point_z[31])
        else $error("negative depth on output");

    // A point at zero depth collapses onto the camera center.
    a_zero_depth_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_point_z == 32'sd0) |-> (o_point_x == 32'sd0 && o_point_y == 32'sd0))
        else $error("nonzero lateral coordinate at zero depth");

endmodule
